// File: rtl/ihr_pkg.sv
// Shared types, constants and helpers of the integral image Haar response block.
package ihr_pkg;

  localparam int unsigned COORD_W  = 10;
  localparam int unsigned DIM_W    = 11;
  localparam int unsigned STORE_W  = 22;
  localparam int unsigned ROWSUM_W = 15;
  localparam int unsigned RESP_W   = 25;
  localparam int unsigned Q_W      = 32;
  localparam int unsigned ACC_W    = 28;

  localparam logic [63:0] NORM_LIMIT = 64'd4294967;

  localparam logic [1:0] STAT_OK           = 2'd0;
  localparam logic [1:0] STAT_NOT_COMPLETE = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE      = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel;
    logic [6:0] query_x;
    logic [6:0] query_y;
  } req_t;

  typedef struct packed {
    logic signed [RESP_W-1:0] response;
    logic [2:0]               level;
    logic [1:0]               orientation;
    logic [1:0]               status;
    logic                     last;
  } res_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_ERR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [ROWSUM_W-1:0]  row_sum;
    logic [1:0]           status;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_ERR,
    ST_Q_RD,
    ST_Q_LVL,
    ST_SQ,
    ST_SQRT,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Corner weight; corners run row by row, top left first.
  function automatic logic signed [3:0] coef(logic [1:0] ori, logic [1:0] cx, logic [1:0] cy);
    logic signed [3:0] w;
    logic [3:0] sel;
    sel = {cy, cx};
    w = 4'sd0;
    case (ori)
      2'd0: begin
        case (sel)
          4'h0, 4'h2: w = 4'sd1;
          4'h1:       w = -4'sd2;
          4'h8, 4'ha: w = -4'sd1;
          4'h9:       w = 4'sd2;
          default:    w = 4'sd0;
        endcase
      end
      2'd1: begin
        case (sel)
          4'h0, 4'h8: w = 4'sd1;
          4'h2, 4'ha: w = -4'sd1;
          4'h4:       w = -4'sd2;
          4'h6:       w = 4'sd2;
          default:    w = 4'sd0;
        endcase
      end
      default: begin
        case (sel)
          4'h0, 4'h2, 4'h8, 4'ha: w = 4'sd1;
          4'h5:                   w = 4'sd4;
          default:                w = -4'sd2;
        endcase
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/integral_image_haar_responses_core.sv
// Load: one request a cycle into the queue unless it is full; each then takes a store update
// (read above, write). Query: 9 corner reads plus one scaling step per level, squares of all
// responses and the 32-step bit-serial square root come before the first result; with scaling
// every result also passes the bit-serial divider. One request is executed at a time.
// Reset clears load position, frame flag and queue, sets both dimensions to 128; store not cleared.
module integral_image_haar_responses_core #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128,
  parameter int unsigned LEVELS     = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ihr_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ihr_pkg::res_t out_res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam logic [ihr_pkg::DIM_W-1:0] MW = ihr_pkg::DIM_W'(MAX_WIDTH);
  localparam logic [ihr_pkg::DIM_W-1:0] MH = ihr_pkg::DIM_W'(MAX_HEIGHT);
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [7:0] width_q, height_q;
  logic       cfg_wr, push, pop, full, empty;
  logic [ihr_pkg::DIM_W-1:0] w_eff, h_eff;
  ihr_pkg::cmd_t cmd_push, cmd_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {24'b0, height_q} : {24'b0, width_q};

  always_comb begin
    w_eff = (width_q == 8'd0) ? ihr_pkg::DIM_W'(1) :
            ((ihr_pkg::DIM_W'(width_q) > MW) ? MW : ihr_pkg::DIM_W'(width_q));
    h_eff = (height_q == 8'd0) ? ihr_pkg::DIM_W'(1) :
            ((ihr_pkg::DIM_W'(height_q) > MH) ? MH : ihr_pkg::DIM_W'(height_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd128;
      height_q <= 8'd128;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) width_q <= pwdata[7:0];
      else height_q <= pwdata[7:0];
    end
  end

  ihr_front #(.LEVELS(LEVELS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .restart_i  (cfg_wr),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_push)
  );

  ihr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_push),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .empty_o (empty)
  );

  ihr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .LEVELS     (LEVELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (cmd_head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

// File: rtl/ihr_ram.sv
// Generic single write, single read RAM with registered read data.
module ihr_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/ihr_fifo.sv
// Two-entry command queue between the front and the back.
module ihr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ihr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ihr_pkg::cmd_t data_o,
  output logic          empty_o
);

  ihr_pkg::cmd_t mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/ihr_front.sv
// Front end: accepts requests, tracks the load raster position and classifies queries.
module ihr_front #(
  parameter int unsigned LEVELS = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ihr_pkg::req_t             in_req_i,
  input  logic [ihr_pkg::DIM_W-1:0] width_i,
  input  logic [ihr_pkg::DIM_W-1:0] height_i,
  input  logic                      restart_i,
  input  logic                      full_i,
  output logic                      push_o,
  output ihr_pkg::cmd_t             cmd_o
);

  localparam logic [ihr_pkg::DIM_W-1:0] HALF = ihr_pkg::DIM_W'(1 << (LEVELS - 1));

  logic [ihr_pkg::COORD_W-1:0]  col_q, col_d, row_q, row_d, col_e, row_e;
  logic [ihr_pkg::ROWSUM_W-1:0] rs_q, rs_d, rs_e, rs_new;
  logic                         fc_q, fc_d, restart_pos, accept;
  logic [ihr_pkg::DIM_W-1:0]    col_n, row_n, qx, qy;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    restart_pos = fc_q || ({1'b0, col_q} >= width_i) || ({1'b0, row_q} >= height_i);
    col_e  = restart_pos ? '0 : col_q;
    row_e  = restart_pos ? '0 : row_q;
    rs_e   = restart_pos ? '0 : rs_q;
    rs_new = rs_e + ihr_pkg::ROWSUM_W'(in_req_i.pixel);
    col_n  = {1'b0, col_e} + ihr_pkg::DIM_W'(1);
    row_n  = {1'b0, row_e} + ihr_pkg::DIM_W'(1);
    qx     = ihr_pkg::DIM_W'(in_req_i.query_x);
    qy     = ihr_pkg::DIM_W'(in_req_i.query_y);

    col_d = col_q;
    row_d = row_q;
    rs_d  = rs_q;
    fc_d  = fc_q;
    push_o = 1'b0;
    cmd_o.kind    = ihr_pkg::CMD_LOAD;
    cmd_o.x       = col_e;
    cmd_o.y       = row_e;
    cmd_o.row_sum = rs_new;
    cmd_o.status  = ihr_pkg::STAT_OK;

    if (restart_i) begin
      col_d = '0;
      row_d = '0;
      rs_d  = '0;
      fc_d  = 1'b0;
    end else if (accept) begin
      push_o = 1'b1;
      if (in_req_i.op == ihr_pkg::OP_LOAD) begin
        fc_d = 1'b0;
        if (col_n >= width_i) begin
          col_d = '0;
          rs_d  = '0;
          if (row_n >= height_i) begin
            row_d = '0;
            fc_d  = 1'b1;
          end else begin
            row_d = row_n[ihr_pkg::COORD_W-1:0];
          end
        end else begin
          col_d = col_n[ihr_pkg::COORD_W-1:0];
          row_d = row_e;
          rs_d  = rs_new;
        end
      end else begin
        cmd_o.x = ihr_pkg::COORD_W'(in_req_i.query_x);
        cmd_o.y = ihr_pkg::COORD_W'(in_req_i.query_y);
        if (!fc_q) begin
          cmd_o.kind   = ihr_pkg::CMD_ERR;
          cmd_o.status = ihr_pkg::STAT_NOT_COMPLETE;
        end else if (qx < HALF || qy < HALF ||
                     qx + HALF >= width_i || qy + HALF >= height_i) begin
          cmd_o.kind   = ihr_pkg::CMD_ERR;
          cmd_o.status = ihr_pkg::STAT_OUTSIDE;
        end else begin
          cmd_o.kind = ihr_pkg::CMD_QUERY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rs_q  <= '0;
      fc_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      rs_q  <= rs_d;
      fc_q  <= fc_d;
    end
  end

endmodule

// File: rtl/ihr_back.sv
// Back end: integral store updates, box sums, norm, bit-serial root and divide.
module ihr_back #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128,
  parameter int unsigned LEVELS     = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ihr_pkg::cmd_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ihr_pkg::res_t out_res_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned N     = 3 * LEVELS;
  localparam int unsigned IW    = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned KW    = $clog2(N + 1);
  localparam int unsigned CW    = ihr_pkg::COORD_W;
  localparam int unsigned QW    = ihr_pkg::Q_W;

  ihr_pkg::state_e state_q, state_d;
  ihr_pkg::cmd_t   cmd_q, cmd_d;
  ihr_pkg::res_t   out_q, out_d;
  logic            out_valid_q, out_valid_d, out_free;

  logic [2:0] lvl_q, lvl_d;
  logic [1:0] cx_q, cx_d, cy_q, cy_d, rcx_q, rcx_d, rcy_q, rcy_d;
  logic       issue_done_q, issue_done_d, rd_valid_q, rd_valid_d;
  logic signed [ihr_pkg::ACC_W-1:0] acc_q [3];
  logic signed [ihr_pkg::ACC_W-1:0] acc_d [3];
  logic signed [QW-1:0] qv_q [N];
  logic signed [QW-1:0] qv_d [N];
  logic [KW-1:0] k_q, k_d;
  logic [63:0]   sq_q, sq_d, prod_q, prod_d, sqv_q, sqv_d;
  logic          prod_valid_q, prod_valid_d;
  logic [31:0]   root_q, root_d;
  logic [35:0]   rem_q, rem_d, rem_n, trial;
  logic [4:0]    it_q, it_d;
  logic [15:0]   r_q, r_d, drem_q, drem_d;
  logic [31:0]   dq_q, dq_d, qf, qa;
  logic [16:0]   dt;
  logic          neg_q, neg_d;
  logic signed [QW-1:0] resp_q, resp_d, qk, qext;
  logic [2:0]    ol_q, ol_d;
  logic [1:0]    oo_q, oo_d;

  logic          we;
  logic [AW-1:0] raddr, head_addr, cmd_addr, corner_addr;
  logic [ihr_pkg::STORE_W-1:0] rdata, wdata;
  logic [CW-1:0] d, xc, yc;
  logic [4:0]    idx5;
  logic [3:0]    sh;

  ihr_ram #(.WIDTH(ihr_pkg::STORE_W), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cmd_addr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign qk          = qv_q[k_q[IW-1:0]];

  always_comb begin
    d  = CW'(1) << lvl_q;
    xc = cmd_q.x + ((cx_q == 2'd2) ? d : '0) - ((cx_q == 2'd0) ? d : '0);
    yc = cmd_q.y + ((cy_q == 2'd2) ? d : '0) - ((cy_q == 2'd0) ? d : '0);
    corner_addr = AW'(yc) * AW'(MAX_WIDTH) + AW'(xc);
    head_addr   = AW'(head_i.y) * AW'(MAX_WIDTH) + AW'(head_i.x);
    cmd_addr    = AW'(cmd_q.y) * AW'(MAX_WIDTH) + AW'(cmd_q.x);
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    lvl_d        = lvl_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    rcx_d        = rcx_q;
    rcy_d        = rcy_q;
    issue_done_d = issue_done_q;
    rd_valid_d   = 1'b0;
    acc_d        = acc_q;
    qv_d         = qv_q;
    k_d          = k_q;
    sq_d         = sq_q;
    prod_d       = prod_q;
    prod_valid_d = prod_valid_q;
    sqv_d        = sqv_q;
    root_d       = root_q;
    rem_d        = rem_q;
    it_d         = it_q;
    r_d          = r_q;
    drem_d       = drem_q;
    dq_d         = dq_q;
    neg_d        = neg_q;
    resp_d       = resp_q;
    ol_d         = ol_q;
    oo_d         = oo_q;
    pop_o        = 1'b0;
    we           = 1'b0;
    raddr        = corner_addr;
    wdata        = ihr_pkg::STORE_W'(cmd_q.row_sum) + ((cmd_q.y == '0) ? '0 : rdata);
    rem_n        = {rem_q[33:0], sqv_q[63:62]};
    trial        = {2'b00, root_q, 2'b01};
    dt           = {drem_q, dq_q[31]};
    qf           = {dq_q[30:0], (dt >= {1'b0, r_q})};
    qa           = qk[QW-1] ? 32'(-qk) : 32'(qk);
    idx5         = 5'(lvl_q) * 5'd3;
    sh           = 4'd14 - {lvl_q, 1'b0};
    qext         = '0;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ihr_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          unique case (head_i.kind)
            ihr_pkg::CMD_LOAD: begin
              raddr   = head_addr - AW'(MAX_WIDTH);
              state_d = ihr_pkg::ST_LOAD_WR;
            end
            ihr_pkg::CMD_QUERY: begin
              lvl_d        = '0;
              cx_d         = '0;
              cy_d         = '0;
              issue_done_d = 1'b0;
              for (int j = 0; j < 3; j++) acc_d[j] = '0;
              state_d      = ihr_pkg::ST_Q_RD;
            end
            default: state_d = ihr_pkg::ST_ERR;
          endcase
        end
      end
      ihr_pkg::ST_LOAD_WR: begin
        we      = 1'b1;
        state_d = ihr_pkg::ST_IDLE;
      end
      ihr_pkg::ST_ERR: begin
        if (out_free) begin
          out_d.response    = '0;
          out_d.level       = '0;
          out_d.orientation = '0;
          out_d.status      = cmd_q.status;
          out_d.last        = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ihr_pkg::ST_IDLE;
        end
      end
      ihr_pkg::ST_Q_RD: begin
        if (!issue_done_q) begin
          rd_valid_d = 1'b1;
          rcx_d      = cx_q;
          rcy_d      = cy_q;
          if (cx_q == 2'd2) begin
            cx_d = '0;
            if (cy_q == 2'd2) issue_done_d = 1'b1;
            else cy_d = cy_q + 2'd1;
          end else begin
            cx_d = cx_q + 2'd1;
          end
        end
        if (rd_valid_q) begin
          for (int j = 0; j < 3; j++) begin
            acc_d[j] = acc_q[j] + $signed({6'b0, rdata}) * ihr_pkg::coef(2'(j), rcx_q, rcy_q);
          end
          if (rcx_q == 2'd2 && rcy_q == 2'd2) state_d = ihr_pkg::ST_Q_LVL;
        end
      end
      ihr_pkg::ST_Q_LVL: begin
        // area division is exact: a left shift by 14 - 2*level
        for (int j = 0; j < 3; j++) begin
          qext = {{(QW - ihr_pkg::ACC_W){acc_q[j][ihr_pkg::ACC_W-1]}}, acc_q[j]};
          qv_d[IW'(idx5 + 5'(j))] = qext <<< sh;
          acc_d[j] = '0;
        end
        if (lvl_q == 3'(LEVELS - 1)) begin
          k_d          = '0;
          sq_d         = '0;
          prod_valid_d = 1'b0;
          state_d      = ihr_pkg::ST_SQ;
        end else begin
          lvl_d        = lvl_q + 3'd1;
          cx_d         = '0;
          cy_d         = '0;
          issue_done_d = 1'b0;
          state_d      = ihr_pkg::ST_Q_RD;
        end
      end
      ihr_pkg::ST_SQ: begin
        if (prod_valid_q) sq_d = sq_q + prod_q;
        if (k_q < KW'(N)) begin
          prod_d       = qa * qa;
          prod_valid_d = 1'b1;
          k_d          = k_q + KW'(1);
        end else begin
          prod_valid_d = 1'b0;
          sqv_d        = sq_d;
          root_d       = '0;
          rem_d        = '0;
          it_d         = '0;
          state_d      = ihr_pkg::ST_SQRT;
        end
      end
      ihr_pkg::ST_SQRT: begin
        sqv_d = {sqv_q[61:0], 2'b00};
        if (rem_n >= trial) begin
          rem_d  = rem_n - trial;
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = rem_n;
          root_d = {root_q[30:0], 1'b0};
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'd31) begin
          r_d     = (sq_q > ihr_pkg::NORM_LIMIT) ? root_d[31:16] : '0;
          k_d     = '0;
          ol_d    = '0;
          oo_d    = '0;
          state_d = ihr_pkg::ST_PREP;
        end
      end
      ihr_pkg::ST_PREP: begin
        if (r_q == '0) begin
          resp_d  = qk;
          state_d = ihr_pkg::ST_EMIT;
        end else begin
          neg_d   = qk[QW-1];
          dq_d    = qa;
          drem_d  = '0;
          it_d    = '0;
          state_d = ihr_pkg::ST_DIV;
        end
      end
      ihr_pkg::ST_DIV: begin
        // restoring divide of the magnitude, one quotient bit per cycle
        drem_d = (dt >= {1'b0, r_q}) ? 16'(dt - {1'b0, r_q}) : dt[15:0];
        dq_d   = qf;
        it_d   = it_q + 5'd1;
        if (it_q == 5'd31) begin
          resp_d  = neg_q ? -$signed(qf) : $signed(qf);
          state_d = ihr_pkg::ST_EMIT;
        end
      end
      ihr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_d.response    = resp_q[ihr_pkg::RESP_W-1:0];
          out_d.level       = ol_q;
          out_d.orientation = oo_q;
          out_d.status      = ihr_pkg::STAT_OK;
          out_d.last        = (k_q == KW'(N - 1));
          out_valid_d       = 1'b1;
          k_d               = k_q + KW'(1);
          if (oo_q == 2'd2) begin
            oo_d = '0;
            ol_d = ol_q + 3'd1;
          end else begin
            oo_d = oo_q + 2'd1;
          end
          state_d = (k_q == KW'(N - 1)) ? ihr_pkg::ST_IDLE : ihr_pkg::ST_PREP;
        end
      end
      default: state_d = ihr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ihr_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      rd_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      rd_valid_q   <= rd_valid_d;
      prod_valid_q <= prod_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    out_q        <= out_d;
    lvl_q        <= lvl_d;
    cx_q         <= cx_d;
    cy_q         <= cy_d;
    rcx_q        <= rcx_d;
    rcy_q        <= rcy_d;
    issue_done_q <= issue_done_d;
    acc_q        <= acc_d;
    qv_q         <= qv_d;
    k_q          <= k_d;
    sq_q         <= sq_d;
    prod_q       <= prod_d;
    sqv_q        <= sqv_d;
    root_q       <= root_d;
    rem_q        <= rem_d;
    it_q         <= it_d;
    r_q          <= r_d;
    drem_q       <= drem_d;
    dq_q         <= dq_d;
    neg_q        <= neg_d;
    resp_q       <= resp_d;
    ol_q         <= ol_d;
    oo_q         <= oo_d;
  end

endmodule

// File: tb/sv/tb.sv
// Testbench for the integral image Haar response core: frames, queries, checks.
module tb;

  localparam int unsigned MAXW = 128;
  localparam int unsigned MAXH = 128;
  localparam int unsigned NLVL = 5;
  localparam int unsigned MARGIN = 1 << (NLVL - 1);
  localparam int unsigned REG_WIDTH = 0;
  localparam int unsigned REG_HEIGHT = 1;
  localparam logic [1:0] ORI_HORIZ = 2'd0;
  localparam logic [1:0] ORI_VERT = 2'd1;
  localparam logic [1:0] ORI_CHECK = 2'd2;
  localparam int unsigned QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ihr_pkg::req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ihr_pkg::res_t out_res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  integral_image_haar_responses_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_res_o(out_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [21:0] integral_mem [MAXW*MAXH];
  logic [14:0] row_sum;
  int unsigned load_col, load_row;
  bit frame_done;
  logic [7:0] width_reg = 8'd128, height_reg = 8'd128;
  ihr_pkg::res_t expected_responses[$];

  int unsigned errors = 0, n_loads = 0, n_queries = 0, n_results = 0;
  bit gaps_on = 1'b1, hold_request = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic int unsigned used_w();
    return (width_reg < 1) ? 1 : (width_reg > MAXW ? MAXW : width_reg);
  endfunction

  function automatic int unsigned used_h();
    return (height_reg < 1) ? 1 : (height_reg > MAXH ? MAXH : height_reg);
  endfunction

  function automatic void restart_frame();
    row_sum = '0;
    load_col = 0;
    load_row = 0;
    frame_done = 1'b0;
  endfunction

  function automatic longint mem_at(int unsigned x, int unsigned y);
    return longint'(integral_mem[(y * MAXW + x) % (MAXW * MAXH)]);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void expect_result(ihr_pkg::res_t e);
    expected_responses = {expected_responses, e};
  endfunction

  function automatic void push_error(logic [1:0] st);
    ihr_pkg::res_t e;
    e = '0;
    e.status = st;
    e.last = 1'b1;
    expect_result(e);
  endfunction

  function automatic void predict_load(logic [7:0] p);
    logic [21:0] above;
    if (frame_done) restart_frame();
    if (load_col >= used_w() || load_row >= used_h()) restart_frame();
    row_sum = row_sum + p;
    above = (load_row > 0) ? integral_mem[(load_row - 1) * MAXW + load_col] : '0;
    integral_mem[load_row * MAXW + load_col] = 22'(row_sum) + above;
    load_col++;
    if (load_col >= used_w()) begin
      load_col = 0;
      row_sum = '0;
      load_row++;
      if (load_row >= used_h()) begin
        load_row = 0;
        frame_done = 1'b1;
      end
    end
  endfunction

  function automatic void predict_query(int unsigned x, int unsigned y);
    longint q[3*NLVL];
    longint tl, tm, tr, ml, mm, mr, bl, bm, br, area, root;
    longint unsigned sq, a;
    int unsigned d;
    ihr_pkg::res_t e;
    if (!frame_done) begin
      push_error(ihr_pkg::STAT_NOT_COMPLETE);
      return;
    end
    if (x < MARGIN || y < MARGIN || x + MARGIN >= used_w() || y + MARGIN >= used_h()) begin
      push_error(ihr_pkg::STAT_OUTSIDE);
      return;
    end
    for (int i = 0; i < NLVL; i++) begin
      d = 1 << i;
      area = longint'(1) << (2 * i + 2);
      tl = mem_at(x - d, y - d); tm = mem_at(x, y - d); tr = mem_at(x + d, y - d);
      ml = mem_at(x - d, y);     mm = mem_at(x, y);     mr = mem_at(x + d, y);
      bl = mem_at(x - d, y + d); bm = mem_at(x, y + d); br = mem_at(x + d, y + d);
      q[3*i]   = (2*bm - 2*tm - bl + tl - br + tr) * 65536 / area;
      q[3*i+1] = (2*mr - tr - 2*ml + tl - br + bl) * 65536 / area;
      q[3*i+2] = (4*mm - 2*tm - 2*ml + tl + br - 2*mr - 2*bm + tr + bl) * 65536 / area;
    end
    sq = 0;
    for (int k = 0; k < 3*NLVL; k++) begin
      a = (q[k] < 0) ? -q[k] : q[k];
      sq += a * a;
    end
    // squared norm above 0.001; a root that floors to zero leaves the responses as they are
    if (sq > 64'(ihr_pkg::NORM_LIMIT)) begin
      root = longint'(floor_sqrt(sq) >> 16);
      if (root > 0)
        for (int k = 0; k < 3*NLVL; k++) q[k] = q[k] / root;
    end
    for (int k = 0; k < 3*NLVL; k++) begin
      e.response = q[k][ihr_pkg::RESP_W-1:0];
      e.level = 3'(k / 3);
      e.orientation = (k % 3 == 0) ? ORI_HORIZ : ((k % 3 == 1) ? ORI_VERT : ORI_CHECK);
      e.status = ihr_pkg::STAT_OK;
      e.last = (k == 3*NLVL - 1);
      expect_result(e);
    end
  endfunction

  function automatic int pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input ihr_pkg::req_t r);
    int gap;
    gap = gaps_on ? pick_delay() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    if (r.op == ihr_pkg::OP_LOAD) begin
      predict_load(r.pixel);
      n_loads++;
    end else begin
      predict_query(r.query_x, r.query_y);
      n_queries++;
    end
  endtask

  task automatic send_load(input logic [7:0] p);
    ihr_pkg::req_t r;
    r.op = ihr_pkg::OP_LOAD;
    r.pixel = p;
    r.query_x = 7'($urandom);
    r.query_y = 7'($urandom);
    send_request(r);
  endtask

  task automatic send_query(input int unsigned x, input int unsigned y);
    ihr_pkg::req_t r;
    r.op = ihr_pkg::OP_QUERY;
    r.pixel = 8'($urandom);
    r.query_x = 7'(x);
    r.query_y = 7'(y);
    send_request(r);
  endtask

  task automatic load_frame();
    for (int y = 0; y < used_h(); y++)
      for (int x = 0; x < used_w(); x++)
        send_load(8'($urandom));
  endtask

  // let everything drain, including queued loads that give no result
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_responses.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic reg_write(input int unsigned idx, input logic [7:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(idx * 4); pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
    restart_frame();
  endtask

  task automatic reg_check(input int unsigned idx, input logic [7:0] want);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= 3'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== want) begin
      $display("%0t reg %0d read: expected %0d actual %0d", $time, idx, want, prdata[7:0]);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_dims(input logic [7:0] w, input logic [7:0] h);
    settle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  task automatic test_register_reset();
    reg_check(REG_WIDTH, 8'd128);
    reg_check(REG_HEIGHT, 8'd128);
  endtask

  task automatic test_query_before_frame();
    send_query(0, 0);
    send_query(127, 127);
    send_query(MARGIN, MARGIN);
  endtask

  task automatic test_smallest_frame();
    set_dims(8'd33, 8'd33);
    reg_check(REG_WIDTH, 8'd33);
    reg_check(REG_HEIGHT, 8'd33);
    load_frame();
    send_query(16, 16);
    send_query(15, 16);
    send_query(16, 17);
    send_query(0, 127);
    send_query(16, 15);
    send_query(17, 16);
  endtask

  task automatic test_output_backpressure();
    settle();
    hold_request = 1'b1;
    gaps_on = 1'b0;
    send_query(16, 16);
    send_query(16, 16);
    repeat (4) send_load(8'($urandom));
    send_query(16, 16);
    gaps_on = 1'b1;
  endtask

  task automatic test_load_restart();
    repeat (10) send_load(8'($urandom));
    send_query(16, 16);
    settle();
    reg_write(REG_WIDTH, 8'd40);
    reg_check(REG_WIDTH, 8'd40);
    send_query(20, 16);
    send_load(8'd7);
    send_query(20, 16);
  endtask

  // result side: stall pattern and checking
  initial begin
    int stall_left;
    ihr_pkg::res_t e;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_responses.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, out_res);
          errors++;
        end else begin
          e = expected_responses.pop_front();
          if (out_res !== e) begin
            $display("%0t mismatch: expected resp=%0d lvl=%0d ori=%0d st=%0d last=%0b",
                     $time, e.response, e.level, e.orientation, e.status, e.last);
            $display("%0t           actual   resp=%0d lvl=%0d ori=%0d st=%0d last=%0b",
                     $time, out_res.response, out_res.level, out_res.orientation,
                     out_res.status, out_res.last);
            errors++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 400;
      end else stall_left = pick_delay();
      out_stall <= (stall_left > 0);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MAXW*MAXH; i++) integral_mem[i] = '0;
    restart_frame();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_query_before_frame();
    test_smallest_frame();
    test_output_backpressure();
    test_load_restart();
    settle();
    $display("Covered %0d pixel loads and %0d queries, %0d results checked,", n_loads,
             n_queries, n_results);
    $display("one 33x33 frame, margin and frame errors, restarts, input gaps, output stalls.");
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: integral_image_haar_responses_core.f
rtl/ihr_pkg.sv
rtl/ihr_ram.sv
rtl/ihr_fifo.sv
rtl/ihr_front.sv
rtl/ihr_back.sv
rtl/integral_image_haar_responses_core.sv
tb/sv/tb.sv
